// ===== rtl/core/rmed_pkg.sv =====
// ----------------------------------------------------------------------------
// rmed_pkg - shared constants and helpers for the running median block
// Widths of the sample path, default store size and select-tree staging.
// ----------------------------------------------------------------------------
package rmed_pkg;

    // sample and pair-sum widths
    localparam int DATA_W = 32;
    localparam int SUM_W  = 33;

    // default number of sorted cells
    localparam int CAPACITY = 256;

    // tree levels between two register ranks in the median select tree
    localparam int LEVELS_PER_REG = 4;

    // register ranks in a select tree of the given depth (root always registered)
    function automatic int tree_latency(input int depth);
        return (depth + LEVELS_PER_REG - 1) / LEVELS_PER_REG;
    endfunction

endpackage

// ===== rtl/core/rmed_cell.sv =====
// ----------------------------------------------------------------------------
// rmed_cell - one slot of the sorted insertion chain
// Holds one sample; on insert keeps it, takes the left neighbor's value or
// takes the new sample, so the row stays in ascending order.
// ----------------------------------------------------------------------------
module rmed_cell (
    input  logic                               clk,
    input  logic                               ins,
    input  logic                               live,
    input  logic signed [rmed_pkg::DATA_W-1:0] smp,
    input  logic signed [rmed_pkg::DATA_W-1:0] prev_val,
    input  logic                               prev_gt,
    output logic signed [rmed_pkg::DATA_W-1:0] val,
    output logic                               gt
);

    logic signed [rmed_pkg::DATA_W-1:0] val_reg;
    logic signed [rmed_pkg::DATA_W-1:0] val_next;

    // stored sample is live and strictly above the new one: it moves right
    assign gt = live && (val_reg > smp);

    // equal samples stay left of the new one
    always_comb
    begin
        if (!ins || (live && !gt))
            val_next = val_reg;
        else if (prev_gt)
            val_next = prev_val;
        else
            val_next = smp;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== rtl/core/rmed_or_tree.sv =====
// ----------------------------------------------------------------------------
// rmed_or_tree - pipelined OR reduction over the cell row
// Only the selected cells drive nonzero leaves, so the OR yields the selected
// word. A register rank sits every LEVELS_PER_REG levels and at the root.
// ----------------------------------------------------------------------------
module rmed_or_tree #(
    parameter int WIDTH  = 2 * rmed_pkg::DATA_W,
    parameter int LEAVES = rmed_pkg::CAPACITY
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] leaf [LEAVES],
    output logic [WIDTH-1:0] root
);

    localparam int DEPTH = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int PAD   = 1 << DEPTH;

    // heap order: node j has children 2j and 2j+1, leaves at PAD..2*PAD-1
    logic [WIDTH-1:0] node_out  [1:2*PAD-1];
    logic [WIDTH-1:0] node_comb [1:PAD-1];
    logic [WIDTH-1:0] node_reg  [1:PAD-1];

    // leaves, padded with zero
    for (genvar i = 0; i < PAD; i++)
    begin : g_leaf
        if (i < LEAVES)
        begin : g_real
            assign node_out[PAD+i] = leaf[i];
        end
        else
        begin : g_pad
            assign node_out[PAD+i] = '0;
        end
    end

    // inner nodes
    for (genvar j = 1; j < PAD; j++)
    begin : g_node
        localparam int HEIGHT = DEPTH - ($clog2(j + 1) - 1);
        assign node_comb[j] = node_out[2*j] | node_out[2*j+1];
        if ((HEIGHT % rmed_pkg::LEVELS_PER_REG) == 0 || j == 1)
        begin : g_reg
            always_ff @(posedge clk)
            begin
                node_reg[j] <= node_comb[j];
            end
            assign node_out[j] = node_reg[j];
        end
        else
        begin : g_comb
            assign node_reg[j] = node_comb[j];
            assign node_out[j] = node_comb[j];
        end
    end

    assign root = node_out[1];

endmodule

// ===== rtl/core/running_median.sv =====
// ----------------------------------------------------------------------------
// running_median - median of a signed sample stream
// Sorted cell row with a pipelined select tree for the middle pair.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry sample and start_req. A beat with
// start_req set empties the store before its sample goes in.
// Output channel: out_valid/out_stall carry median and full_res, one result
// beat for every input beat, in order.
// Each accepted sample is inserted into a row of CAPACITY sorted cells in the
// accept cycle. The two middle cells are then picked out through an OR tree
// with LAT = ceil(log2(CAPACITY)/4) register ranks; the truncated mean is
// formed from the tree root and captured in the output register. The next
// input beat is taken only once that result is loaded, so the block holds
// one sample at a time, and a stalled output can hold off the load further.
// If the store already holds CAPACITY samples and start_req is low, the
// sample is dropped and full_res is set; the median is that of the store.
// A stalled result waits in the output register; the next sample may be
// taken meanwhile, and its result then waits until the output frees up.
// Reset empties the store and leaves both channels idle; no clearing pass.
// ----------------------------------------------------------------------------
module running_median #(
    parameter int CAPACITY = rmed_pkg::CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [rmed_pkg::DATA_W-1:0] sample,
    input  logic                               start_req,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rmed_pkg::DATA_W-1:0] median,
    output logic                               full_res
);

    localparam int DW  = rmed_pkg::DATA_W;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = $clog2(CAPACITY);
    localparam int LAT = rmed_pkg::tree_latency(IW);
    localparam int WW  = $clog2(LAT + 1);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t                  state_reg;
    logic [WW-1:0]           wait_reg;
    logic [CW-1:0]           count_reg;
    logic [IW-1:0]           mid_lo_reg;
    logic [IW-1:0]           mid_hi_reg;
    logic                    drop_reg;
    logic                    out_valid_reg;
    logic signed [DW-1:0]    median_reg;
    logic                    full_reg;

    logic                    in_acc;
    logic                    out_free;
    logic                    res_load;
    logic [CW-1:0]           count_eff;
    logic                    dropped;
    logic [CW-1:0]           count_next;
    logic [CW-1:0]           count_less;

    logic signed [DW-1:0]    cell_val [CAPACITY];
    logic                    cell_gt  [CAPACITY];
    logic [2*DW-1:0]         leaf     [CAPACITY];
    logic [2*DW-1:0]         root;

    logic signed [rmed_pkg::SUM_W-1:0] pair_sum;
    logic signed [rmed_pkg::SUM_W-1:0] pair_adj;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // result goes into the output register this cycle
    assign res_load = (state_reg == ST_BUSY) && (wait_reg == '0) && out_free;

    // store fill after this beat
    assign count_eff  = start_req ? '0 : count_reg;
    assign dropped    = (count_eff == CW'(CAPACITY));
    assign count_next = dropped ? count_eff : count_eff + CW'(1);
    assign count_less = count_next - CW'(1);

    // sorted insertion row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DW-1:0] left_val;
        logic                 left_gt;
        if (i == 0)
        begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_rest
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        rmed_cell u_cell (
            .clk      (clk),
            .ins      (in_acc && !dropped),
            .live     (CW'(i) < count_eff),
            .smp      (sample),
            .prev_val (left_val),
            .prev_gt  (left_gt),
            .val      (cell_val[i]),
            .gt       (cell_gt[i])
        );

        // only the two middle cells drive their word into the tree
        assign leaf[i] = {
            (mid_lo_reg == IW'(i)) ? cell_val[i] : {DW{1'b0}},
            (mid_hi_reg == IW'(i)) ? cell_val[i] : {DW{1'b0}}
        };
    end

    // middle pair select
    rmed_or_tree #(
        .WIDTH  (2 * DW),
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    // mean of the middle pair, truncated toward zero; odd count picks one cell twice
    assign pair_sum = $signed({root[2*DW-1], root[2*DW-1:DW]})
                    + $signed({root[DW-1], root[DW-1:0]});
    assign pair_adj = pair_sum + $signed({{(rmed_pkg::SUM_W-1){1'b0}}, pair_sum[rmed_pkg::SUM_W-1]});

    // control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            mid_lo_reg    <= '0;
            mid_hi_reg    <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !res_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        count_reg  <= count_next;
                        mid_lo_reg <= IW'(count_less >> 1);
                        mid_hi_reg <= IW'(count_next >> 1);
                        drop_reg   <= dropped;
                        wait_reg   <= WW'(LAT);
                        state_reg  <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (wait_reg != '0)
                        wait_reg <= wait_reg - WW'(1);
                    else if (out_free)
                    begin
                        median_reg    <= pair_adj[rmed_pkg::SUM_W-1:1];
                        full_reg      <= drop_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign full_res  = full_reg;

`ifndef SYNTHESIS
    // store fill never passes the cell count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("sample count above capacity");

    // one sample in flight: an accepted beat blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("second beat taken while a sample is in flight");

    // middle pair indexes are equal or adjacent
    a_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_hi_reg == mid_lo_reg) || (mid_hi_reg == mid_lo_reg + IW'(1)))
        else $error("middle pair indexes apart");

    // a finished result never overwrites a stalled beat
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(median_reg)))
        else $error("stalled result beat overwritten");
`endif

endmodule

// ===== bench/running_median_tb.sv =====
// ----------------------------------------------------------------------------
// running_median_tb - self-checking bench for the running median block
// Drives signed samples with sequence restarts, predicts the median of the
// sorted store after each beat, and checks every result beat in order.
// Covers value extremes, odd/even counts with truncating mean, duplicates,
// store overflow with dropped samples, restart on a full store, and output
// backpressure that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module running_median_tb;

    localparam int DATA_W      = rmed_pkg::DATA_W;
    localparam int CAP         = rmed_pkg::CAPACITY;
    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 50;

    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [DATA_W-1:0] median;
        logic                     full;
    } median_beat_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] sample;
    logic                     start_req;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] median;
    logic                     full_res;

    // predictor state: ascending store and fill count
    logic signed [DATA_W-1:0] sorted_vals [CAP];
    int                       stored_cnt;

    median_beat_t             median_due_q [$];
    median_beat_t             due_beat;

    int  err_cnt    = 0;
    int  cycle_cnt  = 0;
    int  items_sent = 0;
    int  rx_wait    = 0;
    int  hold_req   = 0;
    int  hold_left  = 0;
    bit  idle_on    = 1'b1;

    running_median dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .median    (median),
        .full_res  (full_res)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what,
                                   input logic signed [DATA_W-1:0] got,
                                   input logic signed [DATA_W-1:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                     what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // update the store with one accepted beat and queue its expected result
    task automatic track_sample(input logic signed [DATA_W-1:0] value,
                                input logic restart);
        median_beat_t             beat;
        logic signed [DATA_W:0]   pair_sum;
        int                       pos;
        if (restart)
            stored_cnt = 0;
        beat.full = (stored_cnt >= CAP);
        if (!beat.full)
        begin
            // equal values stay ahead of the new one
            pos = stored_cnt;
            while (pos > 0 && sorted_vals[pos-1] > value)
            begin
                sorted_vals[pos] = sorted_vals[pos-1];
                pos--;
            end
            sorted_vals[pos] = value;
            stored_cnt++;
        end
        if (stored_cnt % 2)
            beat.median = sorted_vals[(stored_cnt-1)/2];
        else
        begin
            // 33-bit sum, signed divide truncates toward zero
            pair_sum = {sorted_vals[stored_cnt/2-1][DATA_W-1], sorted_vals[stored_cnt/2-1]}
                     + {sorted_vals[stored_cnt/2][DATA_W-1], sorted_vals[stored_cnt/2]};
            pair_sum = pair_sum / 2;
            beat.median = pair_sum[DATA_W-1:0];
        end
        median_due_q.push_back(beat);
    endtask

    // one input beat; entered and left at a falling edge
    task automatic send_sample(input logic signed [DATA_W-1:0] value, input logic restart);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= value;
        start_req <= restart;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        track_sample(value, restart);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom;
        else if (pick < 8)
            return $urandom_range(0, 16) - 8;
        else if (pick == 8)
            return $urandom_range(0, 1) ? S_MAX : S_MIN;
        else
            return $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 3)
                                        : S_MIN + $urandom_range(0, 3);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (median_due_q.size() == 0)
                report_mismatch("unexpected beat, median", median, '0);
            else
            begin
                due_beat = median_due_q.pop_front();
                if (median !== due_beat.median)
                    report_mismatch("median", median, due_beat.median);
                if (full_res !== due_beat.full)
                    report_mismatch("full_res", DATA_W'(full_res), DATA_W'(due_beat.full));
            end
            rx_wait = idle_on ? $urandom_range(0, 8) : 0;
        end
    end

    // receiver stall: per-beat wait plus an occasional long hold
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // extremes, truncation of the mean, duplicates, restarts
    task automatic test_directed();
        send_sample(32'sd7, 1'b0);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(-32'sd3, 1'b1);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd3, 1'b1);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd5, 1'b1);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd4, 1'b0);
        send_sample(32'sh5555_5555, 1'b1);
        send_sample(32'shAAAA_AAAA, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd1, 1'b0);
    endtask

    // fill the store, overflow it, then restart on a full store
    task automatic test_store_full();
        int i;
        send_sample(draw_sample(), 1'b1);
        for (i = 1; i < CAP + 6; i++)
            send_sample(draw_sample(), 1'b0);
        send_sample(draw_sample(), 1'b1);
        send_sample(draw_sample(), 1'b0);
        send_sample(draw_sample(), 1'b0);
    endtask

    // long receiver hold while the sender keeps offering beats
    task automatic test_output_hold();
        int i;
        idle_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        send_sample(draw_sample(), 1'b1);
        for (i = 0; i < 40; i++)
            send_sample(draw_sample(), 1'b0);
        idle_on = 1'b1;
    endtask

    // random sequences, mostly short, a few long enough to overflow
    task automatic test_random_sequences();
        int seq_len;
        int i;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            seq_len = ($urandom_range(0, 11) == 0) ? $urandom_range(CAP - 6, CAP + 20)
                                                   : $urandom_range(1, 40);
            for (i = 0; i < seq_len && items_sent < ITEM_TARGET; i++)
                send_sample(draw_sample(),
                            (i == 0 && $urandom_range(0, 7) != 0) ||
                            ($urandom_range(0, 99) == 0));
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        start_req  = 1'b0;
        stored_cnt = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_store_full();
        test_output_hold();
        test_random_sequences();
        in_valid <= 1'b0;

        // drain outstanding results
        while (median_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
